// ===== design/dbc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbc_pkg
// Shared constants, stage payload types and the seven-segment encoder for the
// debounced button counter.
// ----------------------------------------------------------------------------
package dbc_pkg;

	localparam int NumButtons  = 8;
	localparam int HoldSamples = 12;
	localparam int CountMax    = 1023;

	localparam int LevelW = 8;
	localparam int MaskW  = 8;
	localparam int CountW = 10;
	localparam int HistW  = HoldSamples + 1;
	localparam int SumW   = CountW + 1;
	localparam int PadW   = (NumButtons > MaskW) ? NumButtons : MaskW;

	localparam logic [HistW-1:0] HistHit = HistW'(1) << HoldSamples;

	localparam logic [7:0] SegBlank = 8'hFF;

	// Reciprocal constants for the decimal split.
	localparam logic [CountW-1:0] Thousand  = CountW'(1000);
	localparam int                HundMul   = 41;
	localparam int                HundShift = 12;
	localparam int                TenMul    = 205;
	localparam int                TenShift  = 11;

	typedef logic [3:0] digit_t;

	typedef struct packed {
		logic [MaskW-1:0]  mask;
		logic [CountW-1:0] count;
	} tally_t;

	typedef struct packed {
		logic [MaskW-1:0]  mask;
		logic [CountW-1:0] count;
		logic              thou;
		digit_t            hund;
		logic [CountW-1:0] rest;
	} split_t;

	// Active-low segments, bit 0 is segment a, bit 7 the decimal point (off).
	function automatic logic [7:0] seg_code(input digit_t d);
		logic [7:0] c;
		case (d)
			4'd0:    c = 8'hC0;
			4'd1:    c = 8'hF9;
			4'd2:    c = 8'hA4;
			4'd3:    c = 8'hB0;
			4'd4:    c = 8'h99;
			4'd5:    c = 8'h92;
			4'd6:    c = 8'h82;
			4'd7:    c = 8'hF8;
			4'd8:    c = 8'h80;
			4'd9:    c = 8'h90;
			default: c = SegBlank;
		endcase
		return c;
	endfunction

endpackage

// ===== design/dbc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbc_if
// Valid/ready channels for button samples and display results.
// ----------------------------------------------------------------------------
interface dbc_btn_if import dbc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [LevelW-1:0] button_levels;

	modport source (output valid, output button_levels, input ready);
	modport sink   (input valid, input button_levels, output ready);
endinterface

interface dbc_disp_if import dbc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [MaskW-1:0]  pressed_mask;
	logic [CountW-1:0] count_value;
	logic [7:0]        thousands_code;
	logic [7:0]        hundreds_code;
	logic [7:0]        tens_code;
	logic [7:0]        ones_code;

	modport source (output valid, output pressed_mask, output count_value,
		output thousands_code, output hundreds_code, output tens_code,
		output ones_code, input ready);
	modport sink   (input valid, input pressed_mask, input count_value,
		input thousands_code, input hundreds_code, input tens_code,
		input ones_code, output ready);
endinterface

// ===== design/dbc_debounce.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbc_debounce
// Per-button shift histories, press detection and the running count.
// ----------------------------------------------------------------------------
module dbc_debounce import dbc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  logic [LevelW-1:0] levels,
	output tally_t            tally_s1
);

	logic [HistW-1:0] hist_q [NumButtons];
	logic [HistW-1:0] hist_next [NumButtons];
	logic [NumButtons-1:0] hit;
	logic [PadW-1:0]       hit_pad;
	logic [CountW-1:0]     count_q;
	logic [SumW-1:0]       sum;
	logic [CountW-1:0]     count_next;

	always_comb begin
		for (int i = 0; i < NumButtons; i++) begin
			// Buttons with no input pin read as pressed.
			hist_next[i] = {hist_q[i][HistW-2:0], (i < LevelW) ? levels[i % LevelW] : 1'b0};
			hit[i]       = (hist_next[i] == HistHit);
		end
		hit_pad    = PadW'(hit);
		sum        = SumW'(count_q) + SumW'(hit);
		count_next = (sum > SumW'(CountMax)) ? CountW'(1) : sum[CountW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumButtons; i++) begin
				hist_q[i] <= '0;
			end
			count_q <= '0;
		end else if (load) begin
			for (int i = 0; i < NumButtons; i++) begin
				hist_q[i] <= hist_next[i];
			end
			count_q <= count_next;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tally_s1.mask  <= hit_pad[MaskW-1:0];
			tally_s1.count <= count_next;
		end
	end

endmodule

// ===== design/dbc_digits.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbc_digits
// First half of the decimal split: thousands and hundreds digits.
// ----------------------------------------------------------------------------
module dbc_digits import dbc_pkg::*; (
	input  logic   clk,
	input  logic   load,
	input  tally_t tally_s1,
	output split_t split_s2
);

	logic              thou;
	logic [CountW-1:0] rest;
	logic [CountW+6:0] prod;

	always_comb begin
		thou = (tally_s1.count >= Thousand);
		rest = thou ? (tally_s1.count - Thousand) : tally_s1.count;
		// rest is below 1000, so multiplying by 41/4096 gives rest / 100 exactly.
		prod = (CountW + 7)'(rest) * (CountW + 7)'(HundMul);
	end

	always_ff @(posedge clk) begin
		if (load) begin
			split_s2.mask  <= tally_s1.mask;
			split_s2.count <= tally_s1.count;
			split_s2.thou  <= thou;
			split_s2.hund  <= digit_t'(prod >> HundShift);
			split_s2.rest  <= rest;
		end
	end

endmodule

// ===== design/dbc_segments.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbc_segments
// Tens and ones digits, leading-zero blanking and segment encoding.
// ----------------------------------------------------------------------------
module dbc_segments import dbc_pkg::*; (
	input  logic   clk,
	input  logic   load,
	input  split_t split_s2,
	dbc_disp_if.source disp,
	input  logic   valid_s3
);

	logic [6:0]  rem;
	logic [14:0] tprod;
	digit_t      tens;
	digit_t      ones;
	logic        blank_h;
	logic        blank_t;

	logic [MaskW-1:0]  mask_s3;
	logic [CountW-1:0] count_s3;
	logic [7:0]        thou_s3;
	logic [7:0]        hund_s3;
	logic [7:0]        tens_s3;
	logic [7:0]        ones_s3;

	always_comb begin
		rem     = 7'(split_s2.rest - CountW'(split_s2.hund) * CountW'(100));
		tprod   = 15'(rem) * 15'(TenMul);
		tens    = digit_t'(tprod >> TenShift);
		ones    = digit_t'(rem - 7'(tens) * 7'd10);
		blank_h = !split_s2.thou && (split_s2.hund == '0);
		blank_t = blank_h && (tens == '0);
	end

	always_ff @(posedge clk) begin
		if (load) begin
			mask_s3  <= split_s2.mask;
			count_s3 <= split_s2.count;
			thou_s3  <= split_s2.thou ? seg_code(digit_t'(1)) : SegBlank;
			hund_s3  <= blank_h ? SegBlank : seg_code(split_s2.hund);
			tens_s3  <= blank_t ? SegBlank : seg_code(tens);
			ones_s3  <= seg_code(ones);
		end
	end

	assign disp.valid          = valid_s3;
	assign disp.pressed_mask   = mask_s3;
	assign disp.count_value    = count_s3;
	assign disp.thousands_code = thou_s3;
	assign disp.hundreds_code  = hund_s3;
	assign disp.tens_code      = tens_s3;
	assign disp.ones_code      = ones_s3;

endmodule

// ===== design/debounced_button_counter_display.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// debounced_button_counter_display
// Debounces eight active-low buttons, counts weighted presses and drives four
// blanked seven-segment digit codes.
// ----------------------------------------------------------------------------
// Channel   Role     Payload
// btn       sink     button_levels (8)
// disp      source   pressed_mask (8), count_value (10), four segment codes (8)
//
// One beat is taken every cycle unless a stalled result has filled the stages;
// its result is offered from the stage-three register. Stage one updates the
// histories and the count, stage two splits off the thousands and hundreds
// digits, stage three finishes the digits and encodes.
// Reset clears the histories, the count and all stage valid bits.
// A stalled result holds its stage; earlier stages keep filling until full.
// ----------------------------------------------------------------------------
module debounced_button_counter_display import dbc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	dbc_btn_if.sink    btn,
	dbc_disp_if.source disp
);

	logic   valid_s1;
	logic   valid_s2;
	logic   valid_s3;
	logic   rdy1;
	logic   rdy2;
	logic   rdy3;
	tally_t tally_s1;
	split_t split_s2;

	assign rdy3      = !valid_s3 || disp.ready;
	assign rdy2      = !valid_s2 || rdy3;
	assign rdy1      = !valid_s1 || rdy2;
	assign btn.ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= btn.valid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
		end
	end

	dbc_debounce u_debounce (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (btn.valid && rdy1),
		.levels   (btn.button_levels),
		.tally_s1 (tally_s1)
	);

	dbc_digits u_digits (
		.clk      (clk),
		.load     (valid_s1 && rdy2),
		.tally_s1 (tally_s1),
		.split_s2 (split_s2)
	);

	dbc_segments u_segments (
		.clk      (clk),
		.load     (valid_s2 && rdy3),
		.split_s2 (split_s2),
		.disp     (disp),
		.valid_s3 (valid_s3)
	);

endmodule
